>>> hdl/crcec_pkg.sv
package crcec_pkg;

	localparam int CRC_W    = 32;
	localparam int DATA_W   = 8;
	localparam int CNT_W    = 4;
	localparam int WB_W     = 3;
	localparam int CFG_IDX_W = 1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BYTES = 1'b1;

	localparam logic [CRC_W-1:0] POLY_RESET  = 32'h0086_4CFB;
	localparam logic [WB_W-1:0]  WIDTH_RESET = 3'd3;
	localparam logic [CNT_W-1:0] BITS_MAX    = 4'd8;

	// Width codes: CRC width is 8 * (code + 1) bits.
	localparam logic [1:0] WCODE_8  = 2'd0;
	localparam logic [1:0] WCODE_16 = 2'd1;
	localparam logic [1:0] WCODE_24 = 2'd2;
	localparam logic [1:0] WCODE_32 = 2'd3;

	typedef struct packed {
		logic [CRC_W-1:0] poly;   // polynomial already masked to the width
		logic [CRC_W-1:0] mask;
		logic [1:0]       wcode;
	} crc_cfg_t;

endpackage

>>> hdl/crcec_cfg_regs.sv
module crcec_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [crcec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcec_pkg::CRC_W-1:0]         cfg_data,
	output crcec_pkg::crc_cfg_t                 cfg
);
	import crcec_pkg::*;

	logic [CRC_W-1:0] poly_q;
	logic [WB_W-1:0]  width_q;
	logic [1:0]       wcode;
	logic [CRC_W-1:0] mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= POLY_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_POLYNOMIAL:  poly_q  <= cfg_data;
				REG_WIDTH_BYTES: width_q <= cfg_data[WB_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range widths saturate: zero acts as one byte, five and up as four.
	always_comb begin
		case (width_q)
			3'd0, 3'd1: wcode = WCODE_8;
			3'd2:       wcode = WCODE_16;
			3'd3:       wcode = WCODE_24;
			default:    wcode = WCODE_32;
		endcase
		case (wcode)
			WCODE_8:  mask = 32'h0000_00FF;
			WCODE_16: mask = 32'h0000_FFFF;
			WCODE_24: mask = 32'h00FF_FFFF;
			default:  mask = 32'hFFFF_FFFF;
		endcase
	end

	assign cfg.poly  = poly_q & mask;
	assign cfg.mask  = mask;
	assign cfg.wcode = wcode;

endmodule

>>> hdl/crcec_update.sv
module crcec_update (
	input  logic [crcec_pkg::CRC_W-1:0]  rem,
	input  logic [crcec_pkg::DATA_W-1:0] data_bits,
	input  logic [crcec_pkg::CNT_W-1:0]  valid_count,
	input  crcec_pkg::crc_cfg_t          cfg,
	output logic [crcec_pkg::CRC_W-1:0]  rem_next
);
	import crcec_pkg::*;

	always_comb begin
		logic [CRC_W-1:0] r;
		logic [CNT_W-1:0] cnt;
		logic             fb;
		r   = rem;
		fb  = 1'b0;
		cnt = (valid_count > BITS_MAX) ? BITS_MAX : valid_count;
		// Up to eight shift-and-XOR steps, first message bit at bit 7.
		for (int k = 0; k < DATA_W; k++) begin
			if (CNT_W'(k) < cnt) begin
				fb = data_bits[DATA_W-1-k] ^ r[{cfg.wcode, 3'b111}];
				r  = {r[CRC_W-2:0], 1'b0} & cfg.mask;
				if (fb) begin
					r = r ^ cfg.poly;
				end
			end
		end
		rem_next = r;
	end

endmodule

>>> hdl/crc_engine_configurable.sv
// Channel   Direction  Handshake                Payload
// cfg       in         cfg_write (no wait)      cfg_index, cfg_data
// in        in         in_valid / in_ready      data_bits, valid_count, last_item
// out       out        out_valid / out_ready    checksum
//
// An item is registered on acceptance and folded into the remainder when it leaves
// the item register, so one item per clock is sustained unless a last item stalls;
// the limit is the eight-step shift-and-XOR network between the item register and
// the remainder register. A checksum is put in the output register as its last
// item leaves; only a second last item stalls behind a checksum not yet taken.
// Reset clears the remainder and loads the default polynomial and width.
module crc_engine_configurable (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [crcec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcec_pkg::CRC_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [crcec_pkg::DATA_W-1:0]        data_bits,
	input  logic [crcec_pkg::CNT_W-1:0]         valid_count,
	input  logic                                last_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [crcec_pkg::CRC_W-1:0]         checksum
);
	import crcec_pkg::*;

	crc_cfg_t         cfg;
	logic             valid_s1;
	logic [DATA_W-1:0] data_bits_s1;
	logic [CNT_W-1:0] valid_count_s1;
	logic             last_item_s1;
	logic [CRC_W-1:0] remainder_q;
	logic [CRC_W-1:0] rem_next;
	logic             out_valid_q;
	logic [CRC_W-1:0] checksum_q;
	logic             advance_s1;

	crcec_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crcec_update u_update (
		.rem         (remainder_q),
		.data_bits   (data_bits_s1),
		.valid_count (valid_count_s1),
		.cfg         (cfg),
		.rem_next    (rem_next)
	);

	// An item without the last mark never needs the output register.
	assign advance_s1 = valid_s1 && (!last_item_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_bits_s1   <= data_bits;
			valid_count_s1 <= valid_count;
			last_item_s1   <= last_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance_s1) begin
				remainder_q <= last_item_s1 ? '0 : rem_next;
			end
			if (advance_s1 && last_item_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_item_s1) begin
			checksum_q <= rem_next & cfg.mask;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule
